// ----- sv/jdz_pkg.sv -----
`default_nettype none

package jdz_pkg;

    // dead zone mode codes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_AXIAL  = 2'd1;
    localparam logic [1:0] MODE_RADIAL = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_LEFT_DZ   = 2'd1;
    localparam logic [1:0] CFG_RIGHT_DZ  = 2'd2;
    localparam logic [1:0] CFG_TRIG_THR  = 2'd3;

    // fraction bits kept on the vector length
    localparam int GUARD_BITS = 8;

endpackage

`default_nettype wire

// ----- sv/jdz_div.sv -----
`default_nettype none

module jdz_div #(
    parameter int NW   = 32,
    parameter int DW   = 15,
    parameter int QW   = 17,
    parameter int SB_W = 1
) (
    input  wire logic            clk,
    input  wire logic [NW-1:0]   num,
    input  wire logic [DW-1:0]   den,
    input  wire logic [SB_W-1:0] sb_in,
    output logic      [QW-1:0]   quo,
    output logic      [SB_W-1:0] sb_out
);

    // one quotient bit per stage; num must stay below den << QW
    logic [NW-1:0]   rem_s  [QW];
    logic [DW-1:0]   den_s  [QW];
    logic [QW-1:0]   q_s    [QW+1];
    logic [SB_W-1:0] sb_s   [QW+1];
    logic [QW-1:0]   take;

    // trial compare of each stage
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            take[k] = (rem_s[k] >> (QW - 1 - k)) >= NW'(den_s[k]);
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        rem_s[0] <= num;
        den_s[0] <= den;
        q_s[0]   <= '0;
        sb_s[0]  <= sb_in;
        for (int k = 0; k < QW - 1; k++)
        begin
            rem_s[k+1] <= take[k] ? rem_s[k] - (NW'(den_s[k]) << (QW - 1 - k)) : rem_s[k];
            den_s[k+1] <= den_s[k];
        end
        for (int k = 0; k < QW; k++)
        begin
            q_s[k+1]  <= take[k] ? q_s[k] | (QW'(1) << (QW - 1 - k)) : q_s[k];
            sb_s[k+1] <= sb_s[k];
        end
    end

    assign quo    = q_s[QW];
    assign sb_out = sb_s[QW];

endmodule

`default_nettype wire

// ----- sv/jdz_sqrt.sv -----
`default_nettype none

module jdz_sqrt #(
    parameter int RTW  = 24,
    parameter int SB_W = 1
) (
    input  wire logic             clk,
    input  wire logic [2*RTW-1:0] rad,
    input  wire logic [SB_W-1:0]  sb_in,
    output logic      [RTW-1:0]   root,
    output logic      [SB_W-1:0]  sb_out
);

    localparam int RW = 2 * RTW;

    // one root bit per stage, remainder kept as rad - root^2
    logic [RW-1:0]   rem_s  [RTW];
    logic [RTW-1:0]  root_s [RTW+1];
    logic [SB_W-1:0] sb_s   [RTW+1];
    logic [RW:0]     trial  [RTW];
    logic [RTW-1:0]  take;

    // trial value (2*root + bit) * bit for each stage
    always_comb
    begin
        for (int k = 0; k < RTW; k++)
        begin
            trial[k] = ((RW+1)'(root_s[k]) << (RTW - k))
                     + ((RW+1)'(1) << (2 * (RTW - 1 - k)));
            take[k]  = {1'b0, rem_s[k]} >= trial[k];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        rem_s[0]  <= rad;
        root_s[0] <= '0;
        sb_s[0]   <= sb_in;
        for (int k = 0; k < RTW - 1; k++)
        begin
            rem_s[k+1] <= take[k] ? rem_s[k] - trial[k][RW-1:0] : rem_s[k];
        end
        for (int k = 0; k < RTW; k++)
        begin
            root_s[k+1] <= take[k] ? root_s[k] | (RTW'(1) << (RTW - 1 - k)) : root_s[k];
            sb_s[k+1]   <= sb_s[k];
        end
    end

    assign root   = root_s[RTW];
    assign sb_out = sb_s[RTW];

endmodule

`default_nettype wire

// ----- sv/jdz_axial.sv -----
`default_nettype none

module jdz_axial #(
    parameter int N   = 16,
    parameter int PAD = 1
) (
    input  wire logic                clk,
    input  wire logic signed [N-1:0] v,
    input  wire logic        [N-2:0] dz,
    output logic      signed [N+1:0] res
);

    localparam int FULL = (1 << (N - 1)) - 1;

    logic [N-1:0]        av;
    logic [N-2:0]        den;
    logic [N-1:0]        m_reg;
    logic                neg_reg;
    logic [2*N-1:0]      prod_reg;
    logic                neg_s1_reg;
    logic [N:0]          q;
    logic                q_neg;
    logic signed [N+1:0] res_reg;
    logic signed [N+1:0] pad_reg [PAD];

    assign av  = v[N-1] ? N'(-v) : N'(v);
    assign den = (N-1)'(FULL) - dz;

    // excess over the dead zone
    always_ff @(posedge clk)
    begin
        m_reg   <= (av > {1'b0, dz}) ? av - {1'b0, dz} : '0;
        neg_reg <= v[N-1];
    end

    // scale by full scale
    always_ff @(posedge clk)
    begin
        prod_reg   <= (2*N)'(m_reg) * (2*N)'(FULL);
        neg_s1_reg <= neg_reg;
    end

    // rounded divide by (full - dz)
    jdz_div #(
        .NW   (2 * N),
        .DW   (N - 1),
        .QW   (N + 1),
        .SB_W (1)
    ) u_div (
        .clk    (clk),
        .num    (prod_reg + (2*N)'(den >> 1)),
        .den    (den),
        .sb_in  (neg_s1_reg),
        .quo    (q),
        .sb_out (q_neg)
    );

    // restore sign
    always_ff @(posedge clk)
    begin
        res_reg <= q_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    // align with the radial lanes
    always_ff @(posedge clk)
    begin
        pad_reg[0] <= res_reg;
        for (int k = 0; k < PAD - 1; k++)
        begin
            pad_reg[k+1] <= pad_reg[k];
        end
    end

    assign res = pad_reg[PAD-1];

endmodule

`default_nettype wire

// ----- sv/jdz_radial.sv -----
`default_nettype none

module jdz_radial #(
    parameter int N = 16
) (
    input  wire logic                clk,
    input  wire logic signed [N-1:0] x,
    input  wire logic signed [N-1:0] y,
    input  wire logic        [N-2:0] dz,
    output logic      signed [N-1:0] ox,
    output logic      signed [N-1:0] oy
);

    localparam int G    = jdz_pkg::GUARD_BITS;
    localparam int FULL = (1 << (N - 1)) - 1;
    localparam int LW   = N + G;
    localparam int SB1  = 2 * N + 4;
    localparam int SB2  = LW + SB1;

    logic [N-1:0]      ax0_reg, ay0_reg, ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic              sx0_reg, sy0_reg, sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic [2*N-1:0]    sqx_reg, sqy_reg, dz2_reg, s_reg, sum;
    logic              zero_reg, big_reg;
    logic [N-2:0]      den;

    logic [LW-1:0]     l8;
    logic [SB1-1:0]    sb1_out;
    logic [2*N+G-1:0]  prod_reg;
    logic [SB2-1:0]    sb2_reg, sb2_out;
    logic [LW-1:0]     q1, t;

    logic [N-1:0]      ax4, ay4;
    logic              sx4, sy4, zero4, big4;
    logic [LW-1:0]     l84;

    logic [2*N+G:0]    px_reg, py_reg;
    logic [LW-1:0]     l8_5_reg;
    logic              sx5_reg, sy5_reg, zero5_reg;
    logic [N:0]        mx, my;
    logic [1:0]        sbx, sby;
    logic [N-2:0]      magx, magy;
    logic signed [N-1:0] ox_reg, oy_reg;

    assign den = (N-1)'(FULL) - dz;

    // magnitudes and signs
    always_ff @(posedge clk)
    begin
        ax0_reg <= x[N-1] ? N'(-x) : N'(x);
        ay0_reg <= y[N-1] ? N'(-y) : N'(y);
        sx0_reg <= x[N-1];
        sy0_reg <= y[N-1];
    end

    // squares
    always_ff @(posedge clk)
    begin
        sqx_reg <= (2*N)'(ax0_reg) * (2*N)'(ax0_reg);
        sqy_reg <= (2*N)'(ay0_reg) * (2*N)'(ay0_reg);
        dz2_reg <= (2*N)'(dz) * (2*N)'(dz);
        ax1_reg <= ax0_reg;
        ay1_reg <= ay0_reg;
        sx1_reg <= sx0_reg;
        sy1_reg <= sy0_reg;
    end

    // squared length and its range flags
    assign sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk)
    begin
        s_reg    <= sum;
        zero_reg <= sum <= dz2_reg;
        big_reg  <= sum > (2*N)'(FULL) * (2*N)'(FULL);
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        sx2_reg  <= sx1_reg;
        sy2_reg  <= sy1_reg;
    end

    // length with guard fraction bits
    jdz_sqrt #(
        .RTW  (LW),
        .SB_W (SB1)
    ) u_sqrt (
        .clk    (clk),
        .rad    ({s_reg, {(2*G){1'b0}}}),
        .sb_in  ({ax2_reg, ay2_reg, sx2_reg, sy2_reg, zero_reg, big_reg}),
        .root   (l8),
        .sb_out (sb1_out)
    );

    // shrunk length numerator
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*N+G)'(l8 - (LW'(dz) << G)) * (2*N+G)'(FULL);
        sb2_reg  <= {l8, sb1_out};
    end

    jdz_div #(
        .NW   (2 * N + G),
        .DW   (N - 1),
        .QW   (LW),
        .SB_W (SB2)
    ) u_div_len (
        .clk    (clk),
        .num    (prod_reg + (2*N+G)'(den >> 1)),
        .den    (den),
        .sb_in  (sb2_reg),
        .quo    (q1),
        .sb_out (sb2_out)
    );

    assign {l84, ax4, ay4, sx4, sy4, zero4, big4} = sb2_out;

    // target length, unit length when outside the circle
    assign t = big4 ? (LW'(FULL) << G) : q1;

    always_ff @(posedge clk)
    begin
        px_reg    <= (2*N+G+1)'(ax4) * (2*N+G+1)'(t);
        py_reg    <= (2*N+G+1)'(ay4) * (2*N+G+1)'(t);
        l8_5_reg  <= l84;
        sx5_reg   <= sx4;
        sy5_reg   <= sy4;
        zero5_reg <= zero4;
    end

    // per-component scale by target over length
    jdz_div #(
        .NW   (2 * N + G + 1),
        .DW   (LW),
        .QW   (N + 1),
        .SB_W (2)
    ) u_div_x (
        .clk    (clk),
        .num    (px_reg + (2*N+G+1)'(l8_5_reg >> 1)),
        .den    (l8_5_reg),
        .sb_in  ({sx5_reg, zero5_reg}),
        .quo    (mx),
        .sb_out (sbx)
    );

    jdz_div #(
        .NW   (2 * N + G + 1),
        .DW   (LW),
        .QW   (N + 1),
        .SB_W (2)
    ) u_div_y (
        .clk    (clk),
        .num    (py_reg + (2*N+G+1)'(l8_5_reg >> 1)),
        .den    (l8_5_reg),
        .sb_in  ({sy5_reg, zero5_reg}),
        .quo    (my),
        .sb_out (sby)
    );

    // saturate, sign, and zero inside the dead zone
    assign magx = (mx > (N+1)'(FULL)) ? (N-1)'(FULL) : mx[N-2:0];
    assign magy = (my > (N+1)'(FULL)) ? (N-1)'(FULL) : my[N-2:0];

    always_ff @(posedge clk)
    begin
        if (sbx[0])
        begin
            ox_reg <= '0;
        end
        else
        begin
            ox_reg <= sbx[1] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        end
        if (sby[0])
        begin
            oy_reg <= '0;
        end
        else
        begin
            oy_reg <= sby[1] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
        end
    end

    assign ox = ox_reg;
    assign oy = oy_reg;

endmodule

`default_nettype wire

// ----- sv/joystick_dead_zone_top.sv -----
// Gamepad dead zone stage.
// Input: raise start with one sample (two stick axis pairs, two triggers);
// the sample is taken at the edge where start is high and busy is low.
// busy stays low, so a new sample may be taken every cycle.
// Output: done pulses for one cycle with the processed sample on the out_*
// ports; the receiver cannot stall and must take it in that cycle.
// The circular lanes set the latency: a root unit (one bit per stage), a length
// divider and a component divider, all pipelined one bit per stage. Throughput is
// one sample per cycle.
// The axis and trigger lanes are padded to the same latency; a final stage
// picks per mode and saturates.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no sample is in flight.
// Reset: clears the in-flight marks and restores mode 1 and the default
// dead zones.
`default_nettype none

module joystick_dead_zone_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [SAMPLE_BITS-1:0] left_x,
    input  wire logic signed [SAMPLE_BITS-1:0] left_y,
    input  wire logic signed [SAMPLE_BITS-1:0] right_x,
    input  wire logic signed [SAMPLE_BITS-1:0] right_y,
    input  wire logic signed [SAMPLE_BITS-1:0] left_trig,
    input  wire logic signed [SAMPLE_BITS-1:0] right_trig,
    output logic                               done,
    output logic      signed [SAMPLE_BITS-1:0] out_left_x,
    output logic      signed [SAMPLE_BITS-1:0] out_left_y,
    output logic      signed [SAMPLE_BITS-1:0] out_right_x,
    output logic      signed [SAMPLE_BITS-1:0] out_right_y,
    output logic             [SAMPLE_BITS-2:0] out_left_trig,
    output logic             [SAMPLE_BITS-2:0] out_right_trig,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [1:0]             cfg_index,
    input  wire logic        [SAMPLE_BITS-2:0] cfg_data
);

    localparam int N    = SAMPLE_BITS;
    localparam int G    = jdz_pkg::GUARD_BITS;
    localparam int FULL = (1 << (N - 1)) - 1;
    localparam int LAT  = 3 * N + 2 * G + 10;
    localparam int PAD  = LAT - (N + 5);

    logic [1:0]   mode_reg;
    logic [N-2:0] left_dz_reg, right_dz_reg, trig_thr_reg;
    logic [N-2:0] ldz, rdz, tth, ldz_ax, rdz_ax, tth_ax;
    logic         accept;
    logic [LAT-1:0] vld_reg;

    logic signed [N+1:0] ax_lx, ax_ly, ax_rx, ax_ry, ax_lt, ax_rt;
    logic signed [N-1:0] rd_lx, rd_ly, rd_rx, rd_ry;

    logic                done_reg;
    logic signed [N-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic        [N-2:0] lt_reg, rt_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= jdz_pkg::MODE_AXIAL;
            left_dz_reg  <= (N-1)'(7849);
            right_dz_reg <= (N-1)'(8689);
            trig_thr_reg <= (N-1)'(3855);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jdz_pkg::CFG_MODE:     mode_reg     <= cfg_data[1:0];
                jdz_pkg::CFG_LEFT_DZ:  left_dz_reg  <= cfg_data;
                jdz_pkg::CFG_RIGHT_DZ: right_dz_reg <= cfg_data;
                jdz_pkg::CFG_TRIG_THR: trig_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // full-scale radius is used one below full scale
    assign ldz = (left_dz_reg  == (N-1)'(FULL)) ? (N-1)'(FULL - 1) : left_dz_reg;
    assign rdz = (right_dz_reg == (N-1)'(FULL)) ? (N-1)'(FULL - 1) : right_dz_reg;
    assign tth = (trig_thr_reg == (N-1)'(FULL)) ? (N-1)'(FULL - 1) : trig_thr_reg;

    // a zero dead zone passes the value through the axis lanes
    assign ldz_ax = (mode_reg == jdz_pkg::MODE_AXIAL) ? ldz : '0;
    assign rdz_ax = (mode_reg == jdz_pkg::MODE_AXIAL) ? rdz : '0;
    assign tth_ax = (mode_reg == jdz_pkg::MODE_NONE)  ? '0  : tth;

    // axis lanes
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_lx (.clk(clk), .v(left_x),     .dz(ldz_ax), .res(ax_lx));
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_ly (.clk(clk), .v(left_y),     .dz(ldz_ax), .res(ax_ly));
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_rx (.clk(clk), .v(right_x),    .dz(rdz_ax), .res(ax_rx));
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_ry (.clk(clk), .v(right_y),    .dz(rdz_ax), .res(ax_ry));
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_lt (.clk(clk), .v(left_trig),  .dz(tth_ax), .res(ax_lt));
    jdz_axial #(.N(N), .PAD(PAD)) u_ax_rt (.clk(clk), .v(right_trig), .dz(tth_ax), .res(ax_rt));

    // circular lanes
    jdz_radial #(.N(N)) u_rd_l (
        .clk (clk), .x(left_x),  .y(left_y),  .dz(ldz), .ox(rd_lx), .oy(rd_ly)
    );
    jdz_radial #(.N(N)) u_rd_r (
        .clk (clk), .x(right_x), .y(right_y), .dz(rdz), .ox(rd_rx), .oy(rd_ry)
    );

    // in-flight marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[LAT-2:0], accept};
            done_reg <= vld_reg[LAT-1];
        end
    end

    function automatic logic signed [N-1:0] sat_stick(input logic signed [N+1:0] a);
        if (a > (N+2)'(FULL))
        begin
            return N'(FULL);
        end
        else if (a < -(N+2)'(FULL))
        begin
            return -N'(FULL);
        end
        return a[N-1:0];
    endfunction

    function automatic logic [N-2:0] clamp_trig(input logic signed [N+1:0] a);
        if (a < 0)
        begin
            return '0;
        end
        else if (a > (N+2)'(FULL))
        begin
            return (N-1)'(FULL);
        end
        return a[N-2:0];
    endfunction

    // merge: pick lane per mode and saturate
    always_ff @(posedge clk)
    begin
        if (mode_reg == jdz_pkg::MODE_RADIAL)
        begin
            lx_reg <= rd_lx;
            ly_reg <= rd_ly;
            rx_reg <= rd_rx;
            ry_reg <= rd_ry;
        end
        else
        begin
            lx_reg <= sat_stick(ax_lx);
            ly_reg <= sat_stick(ax_ly);
            rx_reg <= sat_stick(ax_rx);
            ry_reg <= sat_stick(ax_ry);
        end
        lt_reg <= clamp_trig(ax_lt);
        rt_reg <= clamp_trig(ax_rt);
    end

    assign done           = done_reg;
    assign out_left_x     = lx_reg;
    assign out_left_y     = ly_reg;
    assign out_right_x    = rx_reg;
    assign out_right_y    = ry_reg;
    assign out_left_trig  = lt_reg;
    assign out_right_trig = rt_reg;

    // every item comes out after the fixed latency
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LAT+1) done)
        else $error("item result missing after pipeline latency");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT+1))
        else $error("result without an accepted item");

    a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_left_x != -(N'(FULL)) - N'(1)) && (out_left_y != -(N'(FULL)) - N'(1))
              && (out_right_x != -(N'(FULL)) - N'(1)) && (out_right_y != -(N'(FULL)) - N'(1)))
        else $error("stick output beyond full scale");

endmodule

`default_nettype wire

// ----- tb/joystick_dead_zone_top_tb.sv -----
`timescale 1ns / 1ps

module joystick_dead_zone_top_tb;

    localparam int SB = 16;
    localparam longint FULL = (64'sd1 <<< (SB - 1)) - 1;
    localparam int LATENCY = 3 * SB + 27;

    typedef struct {
        logic signed [SB-1:0] lx, ly, rx, ry;
        logic [SB-2:0]        lt, rt;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SB-1:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
    logic signed [SB-1:0] left_trig = '0, right_trig = '0;
    logic done;
    logic signed [SB-1:0] out_left_x, out_left_y, out_right_x, out_right_y;
    logic [SB-2:0] out_left_trig, out_right_trig;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [SB-2:0] cfg_data = '0;

    // shadow copy of the registers
    logic [1:0]    sh_mode = jdz_pkg::MODE_AXIAL;
    logic [SB-2:0] sh_ldz = 15'd7849, sh_rdz = 15'd8689, sh_thr = 15'd3855;

    sample_t pending_samples[$];
    int errors = 0;
    bit quiet = 1'b0;

    joystick_dead_zone_top #(.SAMPLE_BITS(SB)) u_top (.*);

    always #5 clk = ~clk;

    function automatic longint clip_radius(logic [SB-2:0] r);
        longint v;
        v = longint'(r);
        return (v > FULL - 1) ? FULL - 1 : v;
    endfunction

    function automatic longint div_round(longint num, longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint sat_stick(longint v);
        if (v > FULL) return FULL;
        if (v < -FULL) return -FULL;
        return v;
    endfunction

    function automatic longint isqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - res - bitv;
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint remove_axial(longint v, longint dz);
        longint m, r;
        if (v > dz) m = v - dz;
        else if (v < -dz) m = -v - dz;
        else return 0;
        r = div_round(m * FULL, FULL - dz);
        return (v < 0) ? -r : r;
    endfunction

    // radial dead zone on one stick; magnitudes stay below 2^63
    task automatic remove_radial(input longint x, input longint y, input longint dz,
                                 output longint ox, output longint oy);
        longint ax, ay, s, l8, mx, my, t;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        s = ax * ax + ay * ay;
        if (s <= dz * dz)
        begin
            ox = 0;
            oy = 0;
            return;
        end
        l8 = isqrt(s <<< (2 * jdz_pkg::GUARD_BITS));
        if (s > FULL * FULL)
        begin
            mx = div_round((ax * FULL) <<< jdz_pkg::GUARD_BITS, l8);
            my = div_round((ay * FULL) <<< jdz_pkg::GUARD_BITS, l8);
        end
        else
        begin
            t = div_round((l8 - (dz <<< jdz_pkg::GUARD_BITS)) * FULL, FULL - dz);
            mx = div_round(ax * t, l8);
            my = div_round(ay * t, l8);
        end
        ox = sat_stick((x < 0) ? -mx : mx);
        oy = sat_stick((y < 0) ? -my : my);
    endtask

    function automatic logic [SB-2:0] clamp_trig(longint v);
        if (v < 0) return '0;
        if (v > FULL) return FULL[SB-2:0];
        return v[SB-2:0];
    endfunction

    task automatic predict_sample(input logic signed [SB-1:0] in_v[6], output sample_t o);
        longint v[6];
        longint ldz, rdz, thr;
        ldz = clip_radius(sh_ldz);
        rdz = clip_radius(sh_rdz);
        thr = clip_radius(sh_thr);
        for (int i = 0; i < 6; i++) v[i] = longint'(in_v[i]);
        if (sh_mode == jdz_pkg::MODE_AXIAL)
        begin
            v[0] = remove_axial(v[0], ldz);
            v[1] = remove_axial(v[1], ldz);
            v[2] = remove_axial(v[2], rdz);
            v[3] = remove_axial(v[3], rdz);
        end
        else if (sh_mode == jdz_pkg::MODE_RADIAL)
        begin
            remove_radial(v[0], v[1], ldz, v[0], v[1]);
            remove_radial(v[2], v[3], rdz, v[2], v[3]);
        end
        if (sh_mode != jdz_pkg::MODE_NONE)
        begin
            v[4] = remove_axial(v[4], thr);
            v[5] = remove_axial(v[5], thr);
        end
        o.lx = SB'(sat_stick(v[0]));
        o.ly = SB'(sat_stick(v[1]));
        o.rx = SB'(sat_stick(v[2]));
        o.ry = SB'(sat_stick(v[3]));
        o.lt = clamp_trig(v[4]);
        o.rt = clamp_trig(v[5]);
    endtask

    // send one item, with random idle cycles before it unless quiet is set
    task automatic send_sample(input logic signed [SB-1:0] lx, ly, rx, ry, lt, rt);
        logic signed [SB-1:0] in_v[6];
        sample_t exp_s;
        while (!quiet && $urandom_range(99) < 11)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        in_v = '{lx, ly, rx, ry, lt, rt};
        predict_sample(in_v, exp_s);
        start <= 1'b1;
        left_x <= lx;
        left_y <= ly;
        right_x <= rx;
        right_y <= ry;
        left_trig <= lt;
        right_trig <= rt;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_samples.push_back(exp_s);
    endtask

    task automatic drain_pipe();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (pending_samples.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one register write; the caller drops valid after the last one
    task automatic write_reg(input logic [1:0] idx, input logic [SB-2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            jdz_pkg::CFG_MODE:     sh_mode = val[1:0];
            jdz_pkg::CFG_LEFT_DZ:  sh_ldz = val;
            jdz_pkg::CFG_RIGHT_DZ: sh_rdz = val;
            jdz_pkg::CFG_TRIG_THR: sh_thr = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [1:0] m, input logic [SB-2:0] l, r, t);
        drain_pipe();
        write_reg(jdz_pkg::CFG_MODE, {13'd0, m});
        write_reg(jdz_pkg::CFG_LEFT_DZ, l);
        write_reg(jdz_pkg::CFG_RIGHT_DZ, r);
        write_reg(jdz_pkg::CFG_TRIG_THR, t);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SB-1:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $signed(16'($urandom_range(12000))) - 16'sd6000;
            default: return 16'($urandom);
        endcase
    endfunction

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n && done)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end
            else
            begin
                e = pending_samples.pop_front();
                if (out_left_x !== e.lx)
                begin
                    $display("%0t: out_left_x exp %0d got %0d", $time, e.lx, out_left_x);
                    errors++;
                end
                if (out_left_y !== e.ly)
                begin
                    $display("%0t: out_left_y exp %0d got %0d", $time, e.ly, out_left_y);
                    errors++;
                end
                if (out_right_x !== e.rx)
                begin
                    $display("%0t: out_right_x exp %0d got %0d", $time, e.rx, out_right_x);
                    errors++;
                end
                if (out_right_y !== e.ry)
                begin
                    $display("%0t: out_right_y exp %0d got %0d", $time, e.ry, out_right_y);
                    errors++;
                end
                if (out_left_trig !== e.lt)
                begin
                    $display("%0t: out_left_trig exp %0d got %0d", $time, e.lt,
                             out_left_trig);
                    errors++;
                end
                if (out_right_trig !== e.rt)
                begin
                    $display("%0t: out_right_trig exp %0d got %0d", $time, e.rt,
                             out_right_trig);
                    errors++;
                end
            end
        end
    end

    // extremes under the reset settings, plus negative triggers
    task automatic test_reset_defaults();
        send_sample(16'sh8000, 16'sh7fff, 16'sh0000, 16'sh8001, 16'sh8000, 16'sh7fff);
        send_sample(16'sd7849, -16'sd7850, 16'sd8690, -16'sd8689, 16'sd3855, 16'sd3856);
        send_sample(16'shffff, 16'sh0001, 16'sh7fff, 16'sh7fff, -16'sd1, 16'sh0000);
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 4; m++)
        begin
            set_all(m[1:0], 15'd7849, 15'd8689, 15'd3855);
            send_sample(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
            send_sample(16'sd3000, 16'sd4000, -16'sd20000, 16'sd20000, 16'sd9000, -16'sd9000);
            send_sample(16'sd100, -16'sd100, 16'sd0, 16'sd9000, 16'sd0, 16'sd3855);
        end
    endtask

    // radius at zero and at full scale, threshold at zero and one below full scale
    task automatic test_dead_zone_extremes();
        set_all(jdz_pkg::MODE_RADIAL, 15'h7fff, 15'd0, 15'h7ffe);
        send_sample(16'sh7fff, 16'sh0000, 16'sd1, 16'sd0, 16'sh7fff, 16'sh7ffe);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd1);
        set_all(jdz_pkg::MODE_AXIAL, 15'd0, 15'h7fff, 15'd0);
        send_sample(16'sh8000, 16'sd1, 16'sh7fff, 16'sh8001, 16'sd1, 16'sh7fff);
        send_sample(16'sh7ffe, -16'sd1, 16'sh7ffe, 16'sh8000, 16'sh8000, 16'sd0);
    endtask

    task automatic test_random();
        for (int n = 0; n < 2000; n++)
        begin
            if (n % 250 == 0)
                set_all(2'($urandom_range(3)),
                        ($urandom_range(3) == 0) ? 15'h7fff : 15'($urandom_range(16000)),
                        ($urandom_range(4) == 0) ? 15'd0 : 15'($urandom),
                        15'($urandom_range(10000)));
            quiet = (n >= 600 && n < 900);
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                        rand_axis(), rand_axis());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_each_mode();
        test_dead_zone_extremes();
        test_random();
        drain_pipe();
        if (errors == 0 && pending_samples.size() == 0)
            $display("joystick_dead_zone_top test passed");
        else
            $display("joystick_dead_zone_top test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("joystick_dead_zone_top test failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/jdz_pkg.sv
sv/jdz_div.sv
sv/jdz_sqrt.sv
sv/jdz_axial.sv
sv/jdz_radial.sv
sv/joystick_dead_zone_top.sv
tb/joystick_dead_zone_top_tb.sv
